>>> src/tsfs_pkg.sv
// ----------------------------------------------------------------------------
// tsfs_pkg
// Shared types and codes for the thread slot FIFO scheduler.
// ----------------------------------------------------------------------------
package tsfs_pkg;

    // Default size of the thread table
    localparam int MAX_THREADS_DEF = 32;

    // Command codes
    localparam logic [1:0] ACT_CREATE = 2'd0;
    localparam logic [1:0] ACT_YIELD  = 2'd1;
    localparam logic [1:0] ACT_KILL   = 2'd2;
    localparam logic [1:0] ACT_EXIT   = 2'd3;

    // Yield target kinds (the unused code behaves like a given id)
    localparam logic [1:0] KIND_GIVEN = 2'd0;
    localparam logic [1:0] KIND_ANY   = 2'd1;
    localparam logic [1:0] KIND_SELF  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOMORE  = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;
    localparam logic [1:0] STAT_NONE    = 2'd3;

    // Queue command: optional append, then optional removal by id
    typedef struct packed {
        logic       push_en;
        logic [7:0] push_val;
        logic       remove_en;
        logic [7:0] remove_id;
    } q_cmd_t;

    // Queue command as seen by one cell, with the current fill count
    typedef struct packed {
        logic       push_en;
        logic [7:0] push_val;
        logic       remove_en;
        logic [7:0] remove_id;
        logic [8:0] count;
    } q_cell_ctrl_t;

    // Slot table update: mark one slot used or free
    typedef struct packed {
        logic       set_en;
        logic       clr_en;
        logic [7:0] idx;
    } slot_cmd_t;

endpackage

>>> src/tsfs_q_cell.sv
// ----------------------------------------------------------------------------
// tsfs_q_cell
// One entry of the shifting ready queue: holds an id, compares it with the
// id to remove and takes its right neighbor's id once a match is seen.
// ----------------------------------------------------------------------------
module tsfs_q_cell
    import tsfs_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IDW   = 5
)
(
    input  logic               clk,
    input  q_cell_ctrl_t       ctrl,
    input  logic [IDW-1:0]     nb_entry,
    input  logic               seen_in,
    output logic [IDW-1:0]     entry,
    output logic               seen_out
);

    logic [IDW-1:0] entry_reg;
    logic [IDW-1:0] entry_next;
    logic           occupied;
    logic           match;
    logic           shift;
    logic           at_tail;
    logic           nb_is_tail;

    // Compare against the id to remove; pass the hit to the right
    assign occupied   = 9'(INDEX) < ctrl.count;
    assign match      = ctrl.remove_en && occupied && (entry_reg == ctrl.remove_id[IDW-1:0]);
    assign seen_out   = seen_in | match;
    assign shift      = ctrl.remove_en && seen_out;
    assign at_tail    = ctrl.push_en && (9'(INDEX) == ctrl.count);
    assign nb_is_tail = ctrl.push_en && (9'(INDEX + 1) == ctrl.count);

    // Shift left past the removed id, or take the appended id at the tail
    always_comb
    begin
        entry_next = entry_reg;
        if (shift)
        begin
            entry_next = nb_is_tail ? ctrl.push_val[IDW-1:0] : nb_entry;
        end
        else if (at_tail)
        begin
            entry_next = ctrl.push_val[IDW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> src/tsfs_queue.sv
// ----------------------------------------------------------------------------
// tsfs_queue
// Ready queue as a row of cells with a fill count; head at cell 0.
// Supports append and removal by id in the same cycle.
// ----------------------------------------------------------------------------
module tsfs_queue
    import tsfs_pkg::*;
#(
    parameter int MAX_THREADS = MAX_THREADS_DEF,
    parameter int IDW         = (MAX_THREADS > 2) ? $clog2(MAX_THREADS) : 1,
    parameter int CW          = $clog2(MAX_THREADS + 1)
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  q_cmd_t         cmd,
    output logic [IDW-1:0] head,
    output logic [CW-1:0]  count
);

    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [IDW-1:0] entries [MAX_THREADS];
    logic           seen    [MAX_THREADS+1];
    q_cell_ctrl_t   cell_ctrl;

    // Broadcast the command and the fill count to every cell
    assign cell_ctrl.push_en   = cmd.push_en;
    assign cell_ctrl.push_val  = cmd.push_val;
    assign cell_ctrl.remove_en = cmd.remove_en;
    assign cell_ctrl.remove_id = cmd.remove_id;
    assign cell_ctrl.count     = 9'(count_reg);

    assign seen[0] = 1'b0;

    // Row of cells, each fed by its right neighbor; the last cell is fed by the appended id
    for (genvar i = 0; i < MAX_THREADS; i++)
    begin : g_cell
        logic [IDW-1:0] nb;
        if (i < MAX_THREADS - 1)
        begin : g_mid
            assign nb = entries[i+1];
        end
        else
        begin : g_last
            assign nb = cmd.push_val[IDW-1:0];
        end

        tsfs_q_cell #(
            .INDEX (i),
            .IDW   (IDW)
        ) u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl),
            .nb_entry (nb),
            .seen_in  (seen[i]),
            .entry    (entries[i]),
            .seen_out (seen[i+1])
        );
    end

    // Advance the count by one on append while not full, back by one on a removal hit
    always_comb
    begin
        count_next = count_reg;
        if (cmd.push_en && (count_reg < CW'(MAX_THREADS)))
        begin
            count_next = count_next + CW'(1);
        end
        if (cmd.remove_en && seen[MAX_THREADS])
        begin
            count_next = count_next - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head  = entries[0];
    assign count = count_reg;

endmodule

>>> src/tsfs_slots.sv
// ----------------------------------------------------------------------------
// tsfs_slots
// Table of used thread slots with a lowest-free-slot search from slot 1.
// ----------------------------------------------------------------------------
module tsfs_slots
    import tsfs_pkg::*;
#(
    parameter int MAX_THREADS = MAX_THREADS_DEF,
    parameter int IDW         = (MAX_THREADS > 2) ? $clog2(MAX_THREADS) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  slot_cmd_t              cmd,
    output logic [MAX_THREADS-1:0] used,
    output logic [IDW-1:0]         free_idx,
    output logic                   free_found
);

    logic [MAX_THREADS-1:0] used_reg;
    logic [MAX_THREADS-1:0] used_next;

    // Apply one set or clear
    always_comb
    begin
        used_next = used_reg;
        if (cmd.set_en)
        begin
            used_next[cmd.idx[IDW-1:0]] = 1'b1;
        end
        if (cmd.clr_en)
        begin
            used_next[cmd.idx[IDW-1:0]] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= MAX_THREADS'(1);
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    // Find the lowest free slot above slot 0
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = MAX_THREADS - 1; i >= 1; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx   = IDW'(i);
                free_found = 1'b1;
            end
        end
    end

    assign used = used_reg;

endmodule

>>> src/thread_slot_fifo_scheduler_core.sv
// ----------------------------------------------------------------------------
// thread_slot_fifo_scheduler_core
// Thread scheduler with a slot table, a FIFO ready queue with removal by id
// and the running thread id; one result per command.
//
//  channel | dir | tdata bits (lowest first)
//  --------+-----+----------------------------------------------------------
//  s_axis  | in  | action[1:0] target_kind[3:2] target_id[11:4], zero pad
//  m_axis  | out | status[1:0] res_id[9:2] running_id[17:10], zero pad
//
// A command is captured in ST_IDLE; ST_EXEC then updates the slot
// table, the cell queue and the running id in parallel.
// A new command is taken only in ST_IDLE while the result register is empty or
// being drained, so a stalled output holds the input off.
// Reset clears the slot table to slot 0 used, empties the queue and
// makes thread 0 run; no clearing pass is needed.
// ----------------------------------------------------------------------------
module thread_slot_fifo_scheduler_core
    import tsfs_pkg::*;
#(
    parameter int MAX_THREADS = MAX_THREADS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // action, target_kind, target_id
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // status, res_id, running_id
);

    localparam int IDW = (MAX_THREADS > 2) ? $clog2(MAX_THREADS) : 1;
    localparam int CW  = $clog2(MAX_THREADS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t         state_reg;
    logic [1:0]     action_reg;
    logic [1:0]     kind_reg;
    logic [7:0]     tid_reg;
    logic [IDW-1:0] running_reg;
    logic [IDW-1:0] running_next;
    logic           out_valid_reg;
    logic [1:0]     status_reg;
    logic [1:0]     status_next;
    logic [7:0]     res_reg;
    logic [7:0]     res_next;

    logic [MAX_THREADS-1:0] used;
    logic [IDW-1:0]         free_idx;
    logic                   free_found;
    logic [IDW-1:0]         q_head;
    logic [CW-1:0]          q_count;
    q_cmd_t                 q_cmd;
    slot_cmd_t              s_cmd;

    logic [7:0]     want;
    logic           want_ok;
    logic           tid_ok;
    logic           q_empty;
    logic [7:0]     running8;
    logic           exec;

    assign exec     = (state_reg == ST_EXEC);
    assign q_empty  = (q_count == '0);
    assign running8 = 8'(running_reg);
    assign want     = (kind_reg == KIND_ANY) ? 8'(q_head) : tid_reg;
    assign want_ok  = ({1'b0, want} < 9'(MAX_THREADS)) && used[want[IDW-1:0]];
    assign tid_ok   = ({1'b0, tid_reg} < 9'(MAX_THREADS)) && used[tid_reg[IDW-1:0]];

    tsfs_slots #(
        .MAX_THREADS (MAX_THREADS),
        .IDW         (IDW)
    ) u_slots (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (s_cmd),
        .used       (used),
        .free_idx   (free_idx),
        .free_found (free_found)
    );

    tsfs_queue #(
        .MAX_THREADS (MAX_THREADS),
        .IDW         (IDW),
        .CW          (CW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (q_cmd),
        .head  (q_head),
        .count (q_count)
    );

    // Decode the captured command into table and queue updates
    always_comb
    begin
        q_cmd        = '0;
        s_cmd        = '0;
        status_next  = STAT_OK;
        res_next     = '0;
        running_next = running_reg;
        unique case (action_reg)
            ACT_CREATE:
            begin
                if (free_found)
                begin
                    s_cmd.set_en   = exec;
                    s_cmd.idx      = 8'(free_idx);
                    q_cmd.push_en  = exec;
                    q_cmd.push_val = 8'(free_idx);
                    res_next       = 8'(free_idx);
                end
                else
                begin
                    status_next = STAT_NOMORE;
                end
            end
            ACT_YIELD:
            begin
                if ((kind_reg == KIND_ANY) && q_empty)
                begin
                    status_next = STAT_NONE;
                end
                else if ((kind_reg == KIND_SELF) || (want == running8))
                begin
                    res_next = running8;
                end
                else if (!want_ok)
                begin
                    status_next = STAT_INVALID;
                end
                else if (q_empty)
                begin
                    status_next = STAT_NONE;
                end
                else
                begin
                    q_cmd.push_en   = exec;
                    q_cmd.push_val  = running8;
                    q_cmd.remove_en = exec;
                    q_cmd.remove_id = want;
                    running_next    = want[IDW-1:0];
                    res_next        = want;
                end
            end
            ACT_KILL:
            begin
                if (!tid_ok || (tid_reg == '0) || (tid_reg == running8))
                begin
                    status_next = STAT_INVALID;
                end
                else
                begin
                    q_cmd.remove_en = exec;
                    q_cmd.remove_id = tid_reg;
                    s_cmd.clr_en    = exec;
                    s_cmd.idx       = tid_reg;
                    res_next        = tid_reg;
                end
            end
            ACT_EXIT:
            begin
                if (running_reg != '0)
                begin
                    s_cmd.clr_en = exec;
                    s_cmd.idx    = running8;
                    if (!q_empty)
                    begin
                        q_cmd.remove_en = exec;
                        q_cmd.remove_id = 8'(q_head);
                        running_next    = q_head;
                        res_next        = 8'(q_head);
                    end
                    else
                    begin
                        running_next = '0;
                    end
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    // Take a command only while the result register can accept a new one
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);

    // Hold state, the captured command, the running id and the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
            action_reg    <= '0;
            kind_reg      <= '0;
            tid_reg       <= '0;
            status_reg    <= '0;
            res_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        action_reg <= s_axis_tdata[1:0];
                        kind_reg   <= s_axis_tdata[3:2];
                        tid_reg    <= s_axis_tdata[11:4];
                        state_reg  <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    running_reg   <= running_next;
                    status_reg    <= status_next;
                    res_reg       <= (status_next == STAT_OK) ? res_next : 8'd0;
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, 8'(running_reg), res_reg, status_reg};

`ifndef SYNTHESIS
    // The running thread always owns a used slot
    a_running_used: assert property (@(posedge clk) disable iff (!rst_n)
        used[running_reg])
        else $error("running thread slot is free");

    // The running thread is never queued, so the queue stays below the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CW'(MAX_THREADS - 1))
        else $error("ready queue holds too many ids");

    // An execute cycle always produces a result
    a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> m_axis_tvalid)
        else $error("execute cycle gave no result");

    // Slot table and queue change only in the execute cycle
    a_update_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !exec |=> $stable(used) && $stable(q_count))
        else $error("state changed outside execute cycle");
`endif

endmodule
